// File: hdl/expert_slot_residency_allocator_assert.svh
// Assertion macros used by the residency allocator checker
`ifndef EXPERT_SLOT_RESIDENCY_ALLOCATOR_ASSERT_SVH
`define EXPERT_SLOT_RESIDENCY_ALLOCATOR_ASSERT_SVH

// Consequent checked in the same cycle as the antecedent.
`define ESRA_ASSERT_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Consequent checked in the cycle after the antecedent.
`define ESRA_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: hdl/esra_pkg.sv
// Shared constants, codes and types of the expert slot residency allocator
package esra_pkg;

    localparam int MAX_LAYERS  = 64;
    localparam int MAX_EXPERTS = 256;
    localparam int MAX_SLOTS   = 4096;

    localparam int LAYER_W     = $clog2(MAX_LAYERS);
    localparam int EXPERT_W    = $clog2(MAX_EXPERTS);
    localparam int SLOT_W      = $clog2(MAX_SLOTS);
    localparam int NL_W        = $clog2(MAX_LAYERS + 1);
    localparam int NE_W        = $clog2(MAX_EXPERTS + 1);
    localparam int NS_W        = $clog2(MAX_SLOTS + 1);
    localparam int CNT_W       = NS_W;
    localparam int TABLE_DEPTH = MAX_LAYERS * MAX_EXPERTS;
    localparam int ADDR_W      = $clog2(TABLE_DEPTH);
    localparam int BLOB_W      = 32;
    localparam int OFFSET_W    = SLOT_W + BLOB_W;
    localparam int CMD_W       = 2;
    localparam int STATUS_W    = 3;
    localparam int CFG_ADDR_W  = 3;
    localparam int CFG_DATA_W  = 32;

    localparam logic [CMD_W-1:0] CMD_LOOKUP = 2'd0;
    localparam logic [CMD_W-1:0] CMD_ADMIT  = 2'd1;
    localparam logic [CMD_W-1:0] CMD_CLEAR  = 2'd2;

    localparam logic [STATUS_W-1:0] STATUS_HIT     = 3'd0;
    localparam logic [STATUS_W-1:0] STATUS_ADMIT   = 3'd1;
    localparam logic [STATUS_W-1:0] STATUS_MISS    = 3'd2;
    localparam logic [STATUS_W-1:0] STATUS_RANGE   = 3'd3;
    localparam logic [STATUS_W-1:0] STATUS_CLEARED = 3'd4;

    localparam logic [CFG_ADDR_W-1:0] REG_NUM_LAYERS  = 3'd0;
    localparam logic [CFG_ADDR_W-1:0] REG_NUM_EXPERTS = 3'd1;
    localparam logic [CFG_ADDR_W-1:0] REG_NUM_SLOTS   = 3'd2;
    localparam logic [CFG_ADDR_W-1:0] REG_PER_LAYER   = 3'd3;
    localparam logic [CFG_ADDR_W-1:0] REG_BLOB_BYTES  = 3'd4;

    typedef struct packed {
        logic              valid;
        logic [SLOT_W-1:0] slot;
    } esra_entry_t;

    typedef struct packed {
        logic               rd_en;
        logic [ADDR_W-1:0]  rd_addr;
        logic [LAYER_W-1:0] rd_layer;
        logic               wr_en;
        logic [ADDR_W-1:0]  wr_addr;
        esra_entry_t        wr_entry;
        logic               cnt_wr_en;
        logic [LAYER_W-1:0] cnt_wr_layer;
        logic [CNT_W-1:0]   cnt_wr_data;
        logic               clear;
    } esra_mem_req_t;

endpackage

// File: hdl/expert_slot_residency_allocator.sv
// Expert slot residency allocator top level: configuration, command control and result
// One transaction is in flight at a time. Lookup and admit give a valid result in registered
// steps: the residency entry and layer count are read at the accepting edge, the decision
// with write-back into the same memories follows in the next cycle (S_EVAL), and the
// slot-times-blob-size multiply lands in the output register in S_OUT once the previous
// result has been taken. The next transaction can be accepted in the cycle after the result
// is loaded, provided no sweep or quota division is running. A clear command, any write to
// registers 0 to 4, and reset each start a sweep over all 16384 entries of the residency memory
// (layer counts are zeroed in the same sweep) during which no command is accepted;
// configuration writes are accepted at any time. A register write also restarts the quota
// divider, whose run the sweep hides. Writes past index 4 are ignored.
module expert_slot_residency_allocator
    import esra_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [CFG_ADDR_W-1:0] cfg_addr,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    input  logic                  in_valid,
    output logic                  in_ready,
    input  logic [CMD_W-1:0]      cmd,
    input  logic [LAYER_W-1:0]    layer_index,
    input  logic [EXPERT_W-1:0]   expert_index,
    output logic                  out_valid,
    input  logic                  out_ready,
    output logic [STATUS_W-1:0]   status,
    output logic [SLOT_W-1:0]     slot_index,
    output logic [OFFSET_W-1:0]   slot_offset
);

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_EVAL = 2'd1;
    localparam logic [1:0] S_OUT  = 2'd2;

    logic [NL_W-1:0]   nl_reg, nl_next;
    logic [NE_W-1:0]   ne_reg, ne_next;
    logic [NS_W-1:0]   ns_reg, ns_next;
    logic              plm_reg, plm_next;
    logic [BLOB_W-1:0] blob_reg, blob_next;
    logic              cfg_hit;

    logic [1:0]        state_reg, state_next;
    logic [NS_W-1:0]   shared_reg, shared_next;
    logic              out_valid_reg, out_valid_next;

    logic [CMD_W-1:0]   cmd_reg;
    logic [LAYER_W-1:0] layer_reg;
    logic               range_ok_reg;
    logic [ADDR_W-1:0]  addr_reg;
    logic [NS_W-1:0]    lo_reg;

    logic [STATUS_W-1:0] st_eval_reg, st_eval_next;
    logic [SLOT_W-1:0]   slot_eval_reg, slot_eval_next;
    logic [STATUS_W-1:0] status_reg;
    logic [SLOT_W-1:0]   slot_reg;
    logic [OFFSET_W-1:0] offset_reg;

    logic              in_acc;
    logic              out_load;
    logic              mem_clearing;
    logic              div_busy;
    logic [NS_W-1:0]   quota;
    esra_mem_req_t     mem_req;
    esra_entry_t       rd_entry;
    logic [CNT_W-1:0]  rd_cnt;

    logic [ADDR_W-1:0] acc_addr;
    logic [NS_W-1:0]   acc_lo;
    logic              acc_range_ok;
    logic              is_last;
    logic [NS_W:0]     cand_pl;
    logic [NS_W:0]     hi_pl;
    logic [OFFSET_W-1:0] offset_calc;

    // ---------------- configuration ----------------
    assign cfg_ready = 1'b1;
    assign cfg_hit   = cfg_valid && (cfg_addr <= REG_BLOB_BYTES);

    always_comb
    begin
        nl_next   = nl_reg;
        ne_next   = ne_reg;
        ns_next   = ns_reg;
        plm_next  = plm_reg;
        blob_next = blob_reg;
        if (cfg_valid)
        begin
            case (cfg_addr)
                REG_NUM_LAYERS:
                begin
                    if (cfg_data[NL_W-1:0] == '0)
                        nl_next = NL_W'(1);
                    else if (cfg_data[NL_W-1:0] > NL_W'(MAX_LAYERS))
                        nl_next = NL_W'(MAX_LAYERS);
                    else
                        nl_next = cfg_data[NL_W-1:0];
                end
                REG_NUM_EXPERTS:
                begin
                    if (cfg_data[NE_W-1:0] == '0)
                        ne_next = NE_W'(1);
                    else if (cfg_data[NE_W-1:0] > NE_W'(MAX_EXPERTS))
                        ne_next = NE_W'(MAX_EXPERTS);
                    else
                        ne_next = cfg_data[NE_W-1:0];
                end
                REG_NUM_SLOTS:
                begin
                    if (cfg_data[NS_W-1:0] == '0)
                        ns_next = NS_W'(1);
                    else if (cfg_data[NS_W-1:0] > NS_W'(MAX_SLOTS))
                        ns_next = NS_W'(MAX_SLOTS);
                    else
                        ns_next = cfg_data[NS_W-1:0];
                end
                REG_PER_LAYER:  plm_next  = cfg_data[0];
                REG_BLOB_BYTES: blob_next = cfg_data[BLOB_W-1:0];
                default: ;
            endcase
        end
    end

    esra_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (cfg_hit),
        .dividend (ns_next),
        .divisor  (nl_next),
        .quotient (quota),
        .busy     (div_busy)
    );

    // ---------------- command path ----------------
    assign in_ready = (state_reg == S_IDLE) && !mem_clearing && !div_busy;
    assign in_acc   = in_valid && in_ready;
    assign out_load = (state_reg == S_OUT) && (!out_valid_reg || out_ready);

    assign acc_addr     = ADDR_W'(layer_index * ne_reg + expert_index);
    assign acc_lo       = NS_W'(layer_index * quota);
    assign acc_range_ok = ({1'b0, layer_index} < nl_reg) && ({1'b0, expert_index} < ne_reg);

    assign is_last = ({1'b0, layer_reg} == nl_reg - NL_W'(1));
    assign cand_pl = {1'b0, lo_reg} + {1'b0, rd_cnt};
    assign hi_pl   = is_last ? {1'b0, ns_reg} : ({1'b0, lo_reg} + {1'b0, quota});

    always_comb
    begin
        mem_req          = '0;
        mem_req.rd_en    = in_acc;
        mem_req.rd_addr  = acc_addr;
        mem_req.rd_layer = layer_index;
        mem_req.wr_addr  = addr_reg;
        mem_req.cnt_wr_layer = layer_reg;
        mem_req.cnt_wr_data  = rd_cnt + CNT_W'(1);
        mem_req.clear    = cfg_hit;

        st_eval_next   = st_eval_reg;
        slot_eval_next = slot_eval_reg;
        shared_next    = shared_reg;
        state_next     = state_reg;

        if (cfg_hit)
            shared_next = '0;

        case (state_reg)
            S_IDLE:
            begin
                if (in_acc)
                    state_next = S_EVAL;
            end
            S_EVAL:
            begin
                state_next     = S_OUT;
                st_eval_next   = STATUS_MISS;
                slot_eval_next = '0;
                if (cmd_reg == CMD_CLEAR)
                begin
                    st_eval_next  = STATUS_CLEARED;
                    mem_req.clear = 1'b1;
                    shared_next   = '0;
                end
                else if (!range_ok_reg)
                    st_eval_next = STATUS_RANGE;
                else if (rd_entry.valid)
                begin
                    st_eval_next   = STATUS_HIT;
                    slot_eval_next = rd_entry.slot;
                end
                else if (cmd_reg == CMD_ADMIT)
                begin
                    if (plm_reg)
                    begin
                        if (cand_pl < hi_pl)
                        begin
                            st_eval_next      = STATUS_ADMIT;
                            slot_eval_next    = cand_pl[SLOT_W-1:0];
                            mem_req.wr_en     = 1'b1;
                            mem_req.cnt_wr_en = 1'b1;
                        end
                    end
                    else if (shared_reg < ns_reg)
                    begin
                        st_eval_next   = STATUS_ADMIT;
                        slot_eval_next = shared_reg[SLOT_W-1:0];
                        mem_req.wr_en  = 1'b1;
                        shared_next    = shared_reg + NS_W'(1);
                    end
                end
                mem_req.wr_entry.valid = 1'b1;
                mem_req.wr_entry.slot  = slot_eval_next;
            end
            S_OUT:
            begin
                if (out_load)
                    state_next = S_IDLE;
            end
            default: state_next = S_IDLE;
        endcase
    end

    esra_mem u_mem (
        .clk      (clk),
        .rst_n    (rst_n),
        .req      (mem_req),
        .rd_entry (rd_entry),
        .rd_cnt   (rd_cnt),
        .clearing (mem_clearing)
    );

    assign offset_calc = slot_eval_reg * blob_reg;

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (out_load)
            out_valid_next = 1'b1;
        else if (out_ready)
            out_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            nl_reg        <= NL_W'(1);
            ne_reg        <= NE_W'(1);
            ns_reg        <= NS_W'(1);
            plm_reg       <= 1'b0;
            blob_reg      <= BLOB_W'(1);
            state_reg     <= S_IDLE;
            shared_reg    <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            nl_reg        <= nl_next;
            ne_reg        <= ne_next;
            ns_reg        <= ns_next;
            plm_reg       <= plm_next;
            blob_reg      <= blob_next;
            state_reg     <= state_next;
            shared_reg    <= shared_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_acc)
        begin
            cmd_reg      <= cmd;
            layer_reg    <= layer_index;
            range_ok_reg <= acc_range_ok;
            addr_reg     <= acc_addr;
            lo_reg       <= acc_lo;
        end
        st_eval_reg   <= st_eval_next;
        slot_eval_reg <= slot_eval_next;
        if (out_load)
        begin
            status_reg <= st_eval_reg;
            slot_reg   <= slot_eval_reg;
            offset_reg <= offset_calc;
        end
    end

    assign out_valid   = out_valid_reg;
    assign status      = status_reg;
    assign slot_index  = slot_reg;
    assign slot_offset = offset_reg;

endmodule

// File: hdl/esra_div.sv
// Restoring divider giving the per-layer slot quota, one quotient bit per cycle
module esra_div
    import esra_pkg::*;
(
    input  logic            clk,
    input  logic            rst_n,
    input  logic            start,
    input  logic [NS_W-1:0] dividend,
    input  logic [NL_W-1:0] divisor,
    output logic [NS_W-1:0] quotient,
    output logic            busy
);

    localparam int STEP_W = $clog2(NS_W + 1);

    logic              busy_reg, busy_next;
    logic [STEP_W-1:0] step_reg, step_next;
    logic [NS_W-1:0]   quo_reg, quo_next;
    logic [NL_W-1:0]   rem_reg, rem_next;
    logic [NL_W-1:0]   dvs_reg, dvs_next;
    logic [NL_W:0]     trial;

    assign trial = {rem_reg, quo_reg[NS_W-1]};

    always_comb
    begin
        busy_next = busy_reg;
        step_next = step_reg;
        quo_next  = quo_reg;
        rem_next  = rem_reg;
        dvs_next  = dvs_reg;
        if (start)
        begin
            busy_next = 1'b1;
            step_next = STEP_W'(NS_W);
            quo_next  = dividend;
            rem_next  = '0;
            dvs_next  = divisor;
        end
        else if (busy_reg)
        begin
            if (trial >= {1'b0, dvs_reg})
            begin
                rem_next = NL_W'(trial - {1'b0, dvs_reg});
                quo_next = {quo_reg[NS_W-2:0], 1'b1};
            end
            else
            begin
                rem_next = trial[NL_W-1:0];
                quo_next = {quo_reg[NS_W-2:0], 1'b0};
            end
            step_next = step_reg - STEP_W'(1);
            if (step_reg == STEP_W'(1))
                busy_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            step_reg <= '0;
            quo_reg  <= NS_W'(1);
        end
        else
        begin
            busy_reg <= busy_next;
            step_reg <= step_next;
            quo_reg  <= quo_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        dvs_reg <= dvs_next;
    end

    assign quotient = quo_reg;
    assign busy     = busy_reg;

endmodule

// File: hdl/esra_mem.sv
// Residency and layer-count memories with the clearing sweep
module esra_mem
    import esra_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  esra_mem_req_t    req,
    output esra_entry_t      rd_entry,
    output logic [CNT_W-1:0] rd_cnt,
    output logic             clearing
);

    esra_entry_t      entry_mem [TABLE_DEPTH];
    logic [CNT_W-1:0] cnt_mem   [MAX_LAYERS];

    logic              clearing_reg, clearing_next;
    logic [ADDR_W-1:0] sweep_reg, sweep_next;

    logic               tbl_we;
    logic [ADDR_W-1:0]  tbl_waddr;
    esra_entry_t        tbl_wdata;
    logic               cnt_we;
    logic [LAYER_W-1:0] cnt_waddr;
    logic [CNT_W-1:0]   cnt_wdata;

    always_comb
    begin
        clearing_next = clearing_reg;
        sweep_next    = sweep_reg;
        if (req.clear)
        begin
            clearing_next = 1'b1;
            sweep_next    = '0;
        end
        else if (clearing_reg)
        begin
            sweep_next = sweep_reg + ADDR_W'(1);
            if (sweep_reg == ADDR_W'(TABLE_DEPTH - 1))
                clearing_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clearing_reg <= 1'b1;
            sweep_reg    <= '0;
        end
        else
        begin
            clearing_reg <= clearing_next;
            sweep_reg    <= sweep_next;
        end
    end

    // sweep owns both write ports while it runs; layer counts return to zero
    assign tbl_we    = clearing_reg || req.wr_en;
    assign tbl_waddr = clearing_reg ? sweep_reg : req.wr_addr;
    assign tbl_wdata = clearing_reg ? esra_entry_t'('0) : req.wr_entry;
    assign cnt_we    = clearing_reg ? (sweep_reg < ADDR_W'(MAX_LAYERS)) : req.cnt_wr_en;
    assign cnt_waddr = clearing_reg ? sweep_reg[LAYER_W-1:0] : req.cnt_wr_layer;
    assign cnt_wdata = clearing_reg ? '0 : req.cnt_wr_data;

    always_ff @(posedge clk)
    begin
        if (tbl_we)
            entry_mem[tbl_waddr] <= tbl_wdata;
        if (cnt_we)
            cnt_mem[cnt_waddr] <= cnt_wdata;
    end

    always_ff @(posedge clk)
    begin
        if (req.rd_en)
        begin
            rd_entry <= entry_mem[req.rd_addr];
            rd_cnt   <= cnt_mem[req.rd_layer];
        end
    end

    assign clearing = clearing_reg;

endmodule

// File: hdl/esra_checker.sv
// Port-level checker for the expert slot residency allocator, bound to the top level
`include "expert_slot_residency_allocator_assert.svh"

module esra_checker
    import esra_pkg::*;
(
    input logic                  clk,
    input logic                  rst_n,
    input logic                  cfg_valid,
    input logic                  cfg_ready,
    input logic [CFG_ADDR_W-1:0] cfg_addr,
    input logic [CFG_DATA_W-1:0] cfg_data,
    input logic                  in_valid,
    input logic                  in_ready,
    input logic [CMD_W-1:0]      cmd,
    input logic [LAYER_W-1:0]    layer_index,
    input logic [EXPERT_W-1:0]   expert_index,
    input logic                  out_valid,
    input logic                  out_ready,
    input logic [STATUS_W-1:0]   status,
    input logic [SLOT_W-1:0]     slot_index,
    input logic [OFFSET_W-1:0]   slot_offset
);

    `ESRA_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(status) && $stable(slot_index) && $stable(slot_offset), "result changed while stalled")
    `ESRA_ASSERT_SAME(a_no_slot_zero, out_valid && (status == STATUS_MISS || status == STATUS_RANGE || status == STATUS_CLEARED), slot_index == '0 && slot_offset == '0, "slot reported without residency")
    `ESRA_ASSERT_SAME(a_status_code, out_valid, status == STATUS_HIT || status == STATUS_ADMIT || status == STATUS_MISS || status == STATUS_RANGE || status == STATUS_CLEARED, "undefined status code")
    `ESRA_ASSERT_NEXT(a_one_in_flight, in_valid && in_ready, !in_ready, "second transaction taken while one is in flight")
    `ESRA_ASSERT_NEXT(a_cfg_clears, cfg_valid && cfg_ready && cfg_addr <= REG_BLOB_BYTES, !in_ready, "command taken while table clears after a register write")

endmodule

bind expert_slot_residency_allocator esra_checker u_esra_checker (.*);
